// ===== design/swsr_pkg.sv =====
// Shared constants for the sliding window standard deviation / RMS block.
// Widths follow from the sample width and the window length.
// No dependencies.
package swsr_pkg;

    // Sample and window
    localparam int SAMPLE_W = 24;
    localparam int WINDOW   = 100;
    localparam int WIN_SQ   = WINDOW * WINDOW;

    // Derived widths
    localparam int WW     = $clog2(WINDOW + 1);    // fill count, window constant
    localparam int SLOT_W = $clog2(WINDOW);        // ring address
    localparam int SUM_W  = SAMPLE_W + WW;         // running sum
    localparam int Q_W    = 2 * SAMPLE_W;          // quotient, square root operand
    localparam int SQ_W   = Q_W + WW;              // running sum of squares
    localparam int NUM_W  = Q_W + 2 * WW;          // variance numerator
    localparam int RA_W   = 2 * WW;                // remainder, divide by WINDOW^2
    localparam int RT_W   = SAMPLE_W + 2;          // square root remainder
    localparam int CNT_W  = $clog2(Q_W);           // step counter

    // Divide by constant: quotient built from 16-bit chunks, one reciprocal
    // multiply per chunk, reciprocal rounded up so the floor stays exact
    localparam int CHUNK_W = 16;
    localparam int N_CHUNK = Q_W / CHUNK_W;
    localparam int VA_W    = RA_W + CHUNK_W;       // chunk dividend, divide by WINDOW^2
    localparam int VB_W    = WW + CHUNK_W;         // chunk dividend, divide by WINDOW
    localparam int SHA     = VA_W + RA_W;
    localparam int SHB     = VB_W + WW;
    localparam int PA_W    = 2 * VA_W + 1;
    localparam int PB_W    = 2 * VB_W + 1;
    localparam logic [VA_W:0] RECIP_A =
        (VA_W+1)'(((64'd1 << SHA) + 64'(WIN_SQ - 1)) / 64'(WIN_SQ));
    localparam logic [VB_W:0] RECIP_B =
        (VB_W+1)'(((64'd1 << SHB) + 64'(WINDOW - 1)) / 64'(WINDOW));

endpackage

// ===== design/sliding_window_sd_rms_top.sv =====
// Sliding window standard deviation and RMS over the last WINDOW samples.
// Ring memory, running sums, two reciprocal dividers and two square roots.
// Depends on swsr_pkg.
//
//   channel | valid   | stall   | payload
//   --------+---------+---------+------------------------------------
//   input   | i_valid | o_stall | i_sample
//   output  | o_valid | i_stall | o_std_dev, o_rms, o_window_full
//
// Requests are not overlapped: o_stall is high from acceptance until the result is
// loaded into the output register. In between come the ring read and sum update, the
// two dividers (three 16-bit chunks, a reciprocal multiply and a remainder step each),
// the two square root units, which form SAMPLE_W (24) result bits, and the load of the
// output register, which waits while a stalled result still holds it. The next request
// is taken once the result is in the output register, even while it is stalled.
// Synchronous active-low reset clears sums, counters and the output valid;
// the ring needs no clearing since an entry is read only after it is written.
module sliding_window_sd_rms_top
    import swsr_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [SAMPLE_W-1:0] i_sample,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [SAMPLE_W-1:0] o_std_dev,
    output logic [SAMPLE_W-1:0] o_rms,
    output logic                o_window_full
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQ_OLD,
        S_SQ_NEW,
        S_ACC,
        S_SCALE,
        S_DIFF,
        S_DIV_MUL,
        S_DIV_REM,
        S_ROOT,
        S_DONE
    } t_state;

    t_state                r_state;
    logic [SAMPLE_W-1:0]   ring [WINDOW];
    logic [SAMPLE_W-1:0]   r_rd_data;
    logic [SAMPLE_W-1:0]   r_sample;
    logic [SLOT_W-1:0]     r_slot;
    logic [WW-1:0]         r_fill;
    logic                  r_evict;
    logic [SUM_W-1:0]      r_sum;
    logic [SQ_W-1:0]       r_sumsq;
    logic [Q_W-1:0]        r_prod;
    logic [NUM_W-1:0]      r_sum2;
    logic [NUM_W-1:0]      r_wsq;
    logic [CNT_W-1:0]      r_cnt;
    // divider lanes: a = variance, b = mean square
    logic [RA_W-1:0]       r_ra;
    logic [WW-1:0]         r_rb;
    logic [Q_W-1:0]        r_qa;
    logic [Q_W-1:0]        r_qb;
    logic [CHUNK_W-1:0]    r_qca;
    logic [CHUNK_W-1:0]    r_qcb;
    // square root lanes
    logic [RT_W-1:0]       r_sra;
    logic [RT_W-1:0]       r_srb;
    logic [SAMPLE_W-1:0]   r_rta;
    logic [SAMPLE_W-1:0]   r_rtb;
    logic                  r_out_valid;
    logic [SAMPLE_W-1:0]   r_std_dev;
    logic [SAMPLE_W-1:0]   r_rms;
    logic                  r_window_full;

    logic                  w_in_acc;
    logic                  w_out_acc;
    logic                  w_load;
    logic [VA_W-1:0]       w_va;
    logic [VB_W-1:0]       w_vb;
    logic [PA_W-1:0]       w_pa;
    logic [PB_W-1:0]       w_pb;
    logic [RA_W-1:0]       n_ra;
    logic [WW-1:0]         n_rb;
    logic [RT_W+1:0]       w_sta;
    logic [RT_W+1:0]       w_stb;
    logic [RT_W+1:0]       w_trya;
    logic [RT_W+1:0]       w_tryb;
    logic                  w_rge_a;
    logic                  w_rge_b;
    logic [NUM_W-1:0]      w_num;

    assign o_stall   = (r_state != S_IDLE);
    assign w_in_acc  = i_valid && (r_state == S_IDLE);
    assign w_out_acc = r_out_valid && !i_stall;
    assign w_load    = (r_state == S_DONE) && (!r_out_valid || !i_stall);

    assign o_valid       = r_out_valid;
    assign o_std_dev     = r_std_dev;
    assign o_rms         = r_rms;
    assign o_window_full = r_window_full;

    // Ring memory: read the entry about to be overwritten, then write the new sample
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_rd_data    <= ring[r_slot];
            ring[r_slot] <= i_sample;
        end
    end

    // One chunk per lane: remainder joins the next 16 dividend bits
    always_comb begin
        w_va = {r_ra, r_qa[Q_W-1 -: CHUNK_W]};
        w_vb = {r_rb, r_qb[Q_W-1 -: CHUNK_W]};
        w_pa = w_va * RECIP_A;
        w_pb = w_vb * RECIP_B;
        n_ra = RA_W'(w_va - VA_W'(r_qca) * VA_W'(WIN_SQ));
        n_rb = WW'(w_vb - VB_W'(r_qcb) * VB_W'(WINDOW));
    end

    // One square root digit per lane, operand shifts out of the quotient register
    always_comb begin
        w_sta   = {r_sra, r_qa[Q_W-1 -: 2]};
        w_stb   = {r_srb, r_qb[Q_W-1 -: 2]};
        w_trya  = {2'b00, r_rta, 2'b01};
        w_tryb  = {2'b00, r_rtb, 2'b01};
        w_rge_a = (w_sta >= w_trya);
        w_rge_b = (w_stb >= w_tryb);
    end

    // Variance numerator, clamped at zero
    assign w_num = (r_wsq >= r_sum2) ? (r_wsq - r_sum2) : '0;

    // Sequencer and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_slot        <= '0;
            r_fill        <= '0;
            r_evict       <= 1'b0;
            r_sum         <= '0;
            r_sumsq       <= '0;
            r_cnt         <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            // load a finished result, else drop the output once taken
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (w_out_acc) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_sample <= i_sample;
                        r_evict  <= (r_fill == WW'(WINDOW));
                        if (r_fill != WW'(WINDOW)) begin
                            r_fill <= r_fill + 1'b1;
                        end
                        r_slot   <= (r_slot == SLOT_W'(WINDOW - 1)) ? '0 : r_slot + 1'b1;
                        r_state  <= S_SQ_OLD;
                    end
                end
                S_SQ_OLD: begin
                    r_prod  <= Q_W'(r_rd_data) * Q_W'(r_rd_data);
                    r_sum   <= r_sum + SUM_W'(r_sample)
                               - (r_evict ? SUM_W'(r_rd_data) : '0);
                    r_state <= S_SQ_NEW;
                end
                S_SQ_NEW: begin
                    r_sumsq <= r_sumsq - (r_evict ? SQ_W'(r_prod) : '0);
                    r_prod  <= Q_W'(r_sample) * Q_W'(r_sample);
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_sumsq <= r_sumsq + SQ_W'(r_prod);
                    r_sum2  <= NUM_W'(r_sum) * NUM_W'(r_sum);
                    r_state <= S_SCALE;
                end
                S_SCALE: begin
                    r_wsq   <= NUM_W'(r_sumsq) * NUM_W'(WINDOW);
                    r_state <= S_DIFF;
                end
                S_DIFF: begin
                    // upper bits are below the divisor, so only Q_W quotient bits remain
                    r_ra    <= w_num[NUM_W-1:Q_W];
                    r_qa    <= w_num[Q_W-1:0];
                    r_rb    <= r_sumsq[SQ_W-1:Q_W];
                    r_qb    <= r_sumsq[Q_W-1:0];
                    r_sra   <= '0;
                    r_srb   <= '0;
                    r_rta   <= '0;
                    r_rtb   <= '0;
                    r_cnt   <= '0;
                    r_state <= S_DIV_MUL;
                end
                S_DIV_MUL: begin
                    // quotient chunk from the reciprocal product
                    r_qca   <= w_pa[SHA +: CHUNK_W];
                    r_qcb   <= w_pb[SHB +: CHUNK_W];
                    r_state <= S_DIV_REM;
                end
                S_DIV_REM: begin
                    // keep the remainder, shift the chunk into the quotient
                    r_ra <= n_ra;
                    r_rb <= n_rb;
                    r_qa <= {r_qa[Q_W-CHUNK_W-1:0], r_qca};
                    r_qb <= {r_qb[Q_W-CHUNK_W-1:0], r_qcb};
                    if (r_cnt == CNT_W'(N_CHUNK - 1)) begin
                        r_cnt   <= '0;
                        r_state <= S_ROOT;
                    end else begin
                        r_cnt   <= r_cnt + 1'b1;
                        r_state <= S_DIV_MUL;
                    end
                end
                S_ROOT: begin
                    r_sra <= w_rge_a ? RT_W'(w_sta - w_trya) : RT_W'(w_sta);
                    r_srb <= w_rge_b ? RT_W'(w_stb - w_tryb) : RT_W'(w_stb);
                    r_rta <= {r_rta[SAMPLE_W-2:0], w_rge_a};
                    r_rtb <= {r_rtb[SAMPLE_W-2:0], w_rge_b};
                    r_qa  <= {r_qa[Q_W-3:0], 2'b00};
                    r_qb  <= {r_qb[Q_W-3:0], 2'b00};
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(SAMPLE_W - 1)) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    // hold until the output register is free
                    if (w_load) begin
                        r_std_dev     <= r_rta;
                        r_rms         <= r_rtb;
                        r_window_full <= (r_fill == WW'(WINDOW));
                        r_state       <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Fill count never passes the window length
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= WW'(WINDOW))
        else $error("fill count beyond window");

    // Until the window is full the write slot tracks the fill count
    a_slot_tracks_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill != WW'(WINDOW)) |-> (WW'(r_slot) == r_fill))
        else $error("write slot out of step with fill count");

    // A new result appears only from the final sequencer state
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> ($past(r_state) == S_DONE))
        else $error("output valid raised outside completion");

    // Eviction is only flagged once the window had filled
    a_evict_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SQ_OLD && r_evict) |-> (r_fill == WW'(WINDOW)))
        else $error("eviction before window full");

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for sliding_window_sd_rms_top: a directed table, then random
// sample blocks, each result checked against a window standard deviation / RMS predictor.
// Depends on swsr_pkg and the sliding_window_sd_rms_top RTL.
module testbench
    import swsr_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 1950;
    localparam int QUIET_TAIL   = 200;   // final items with no idling on either side
    localparam int DRAIN_CYCLES = 200;   // settle time after the last expected result

    typedef struct packed {
        logic [SAMPLE_W-1:0] std_dev;
        logic [SAMPLE_W-1:0] rms;
        logic                window_full;
    } t_window_stats;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                known;
        t_window_stats       stats;
    } t_sample_row;

    typedef enum int {
        MODE_UNIFORM, MODE_MAX, MODE_ZERO, MODE_FLAT, MODE_SMALL, MODE_SWING, MODE_NOISY
    } t_sample_mode;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_stall;
    logic [SAMPLE_W-1:0] i_sample;
    logic                o_valid;
    logic                i_stall;
    logic [SAMPLE_W-1:0] o_std_dev;
    logic [SAMPLE_W-1:0] o_rms;
    logic                o_window_full;

    // Window model state
    logic [SAMPLE_W-1:0] ring_model [WINDOW];
    int unsigned         ring_slot;
    int unsigned         ring_fill;
    logic [63:0]         sum_model;
    logic [63:0]         sum_sq_model;

    t_window_stats pending_stats [$];
    bit            failed;
    bit            idle_on;
    int            stall_left;

    sliding_window_sd_rms_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_sample      (i_sample),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_std_dev     (o_std_dev),
        .o_rms         (o_rms),
        .o_window_full (o_window_full)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Floor of the square root of a 64-bit value, one result bit per pass
    function automatic logic [SAMPLE_W-1:0] floor_root(input logic [63:0] x);
        logic [63:0] root;
        logic [63:0] bit_val;
        logic [63:0] rest;
        root    = '0;
        rest    = x;
        bit_val = 64'h4000_0000_0000_0000;
        while (bit_val > rest)
            bit_val = bit_val >> 2;
        while (bit_val != 0) begin
            if (rest >= root + bit_val) begin
                rest = rest - (root + bit_val);
                root = (root >> 1) + bit_val;
            end else begin
                root = root >> 1;
            end
            bit_val = bit_val >> 2;
        end
        return root[SAMPLE_W-1:0];
    endfunction

    // Push one sample into the window and return the statistics over it
    function automatic t_window_stats advance_window(input logic [SAMPLE_W-1:0] sample);
        t_window_stats stats;
        logic [63:0]   old_val;
        logic [63:0]   new_val;
        logic [127:0]  scaled_sq;
        logic [127:0]  sum_squared;
        logic [127:0]  variance;
        new_val = {40'd0, sample};
        if (ring_fill >= WINDOW) begin
            old_val      = {40'd0, ring_model[ring_slot]};
            sum_model    = sum_model - old_val;
            sum_sq_model = sum_sq_model - old_val * old_val;
        end else begin
            ring_fill = ring_fill + 1;
        end
        sum_model    = sum_model + new_val;
        sum_sq_model = sum_sq_model + new_val * new_val;
        ring_model[ring_slot] = sample;
        ring_slot = (ring_slot + 1 >= WINDOW) ? 0 : ring_slot + 1;

        scaled_sq   = {64'd0, sum_sq_model} * 128'(WINDOW);
        sum_squared = {64'd0, sum_model} * {64'd0, sum_model};
        if (scaled_sq < sum_squared)
            variance = '0;
        else
            variance = (scaled_sq - sum_squared) / 128'(WIN_SQ);
        stats.std_dev     = floor_root(variance[63:0]);
        stats.rms         = floor_root(sum_sq_model / 64'(WINDOW));
        stats.window_full = (ring_fill >= WINDOW);
        return stats;
    endfunction

    // Offer one request and hold it until accepted, then record its expected result
    task automatic send_sample(input logic [SAMPLE_W-1:0] sample, input bit known,
                               input t_window_stats typed);
        t_window_stats predicted;
        i_valid  <= 1'b1;
        i_sample <= sample;
        do @(posedge i_clk); while (o_stall);
        predicted = advance_window(sample);
        pending_stats.push_back(known ? typed : predicted);
    endtask

    task automatic hold_off(input int cycles);
        if (i_valid)
            i_valid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // Drop valid and wait for every outstanding result
    task automatic drain_results();
        if (i_valid)
            i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_stats.size() != 0)
            @(posedge i_clk);
    endtask

    // Check results at the edge they are taken, then pick the next stall value
    always @(posedge i_clk) begin
        t_window_stats want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_stats.size() == 0) begin
                $error("unexpected result: std_dev %0d rms %0d window_full %0d",
                       o_std_dev, o_rms, o_window_full);
                failed = 1'b1;
            end else begin
                want = pending_stats.pop_front();
                if (o_std_dev !== want.std_dev) begin
                    $error("std_dev: expected %0d, actual %0d", want.std_dev, o_std_dev);
                    failed = 1'b1;
                end
                if (o_rms !== want.rms) begin
                    $error("rms: expected %0d, actual %0d", want.rms, o_rms);
                    failed = 1'b1;
                end
                if (o_window_full !== want.window_full) begin
                    $error("window_full: expected %0d, actual %0d",
                           want.window_full, o_window_full);
                    failed = 1'b1;
                end
            end
        end
        if (stall_left > 0) begin
            i_stall    <= 1'b1;
            stall_left <= stall_left - 1;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            i_stall    <= 1'b1;
            stall_left <= $urandom_range(0, 2);
        end else begin
            i_stall <= 1'b0;
        end
    end

    // Hard limit on run length
    initial begin
        #10ms;
        $display("sliding_window_sd_rms_top: mismatch");
        $finish;
    end

    initial begin
        t_sample_row         directed [$];
        t_sample_row         row;
        t_sample_mode        mode;
        logic [SAMPLE_W-1:0] flat_value;
        logic [SAMPLE_W-1:0] sample;
        int                  sent;
        int                  block_len;
        int                  k;

        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        i_sample   = '0;
        i_stall    = 1'b0;
        failed     = 1'b0;
        idle_on    = 1'b0;
        stall_left = 0;
        ring_slot  = 0;
        ring_fill  = 0;
        sum_model    = '0;
        sum_sq_model = '0;

        // Directed rows: the first two read straight off the formulas
        directed = '{
            '{24'd0,        1'b1, '{24'd0, 24'd0, 1'b0}},
            '{24'd10,       1'b1, '{24'd0, 24'd1, 1'b0}},
            '{24'hFFFFFF,   1'b0, '0}, '{24'hFFFFFF, 1'b0, '0},
            '{24'd0,        1'b0, '0}, '{24'h800000, 1'b0, '0},
            '{24'h7FFFFF,   1'b0, '0}, '{24'd1,      1'b0, '0},
            '{24'hAAAAAA,   1'b0, '0}, '{24'h555555, 1'b0, '0},
            '{24'hFFFFFE,   1'b0, '0}, '{24'h000001, 1'b0, '0},
            '{24'hF0F0F0,   1'b0, '0}, '{24'h0F0F0F, 1'b0, '0},
            '{24'd100,      1'b0, '0}, '{24'd100,    1'b0, '0},
            '{24'hFFFFFF,   1'b0, '0}, '{24'd0,      1'b0, '0},
            '{24'h123456,   1'b0, '0}, '{24'hFEDCBA, 1'b0, '0}
        };

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, back to back with a few gaps
        foreach (directed[i]) begin
            row = directed[i];
            send_sample(row.sample, row.known, row.stats);
            if (i % 4 == 3)
                hold_off($urandom_range(1, 3));
        end
        drain_results();

        // Random blocks: max, zero, flat and swing blocks are long enough to fill the whole window
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            mode       = t_sample_mode'($urandom_range(0, 6));
            flat_value = SAMPLE_W'($urandom);
            if (mode == MODE_UNIFORM || mode == MODE_SMALL || mode == MODE_NOISY)
                block_len = $urandom_range(20, 150);
            else
                block_len = $urandom_range(100, 220);
            idle_on = (sent < RANDOM_ITEMS - QUIET_TAIL) && ($urandom_range(0, 3) != 0);
            if (sent < RANDOM_ITEMS - QUIET_TAIL && $urandom_range(0, 3) == 0)
                drain_results();
            for (k = 0; k < block_len && sent < RANDOM_ITEMS; k++) begin
                case (mode)
                    MODE_UNIFORM: sample = SAMPLE_W'($urandom);
                    MODE_MAX:     sample = 24'hFFFFFF;
                    MODE_ZERO:    sample = 24'd0;
                    MODE_FLAT:    sample = flat_value;
                    MODE_SMALL:   sample = SAMPLE_W'($urandom_range(0, 255));
                    MODE_SWING:   sample = k[0] ? 24'hFFFFFF : 24'd0;
                    default:      sample = flat_value ^ 24'($urandom_range(0, 1023));
                endcase
                if (sent >= RANDOM_ITEMS - QUIET_TAIL)
                    idle_on = 1'b0;
                send_sample(sample, 1'b0, '0);
                sent++;
                if (idle_on && $urandom_range(0, 4) == 0)
                    hold_off($urandom_range(1, 3));
            end
        end

        // Wait out the remaining results, then watch for strays
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (!failed)
            $display("sliding_window_sd_rms_top: match");
        else
            $display("sliding_window_sd_rms_top: mismatch");
        $finish;
    end

endmodule

// ===== files.f =====
design/swsr_pkg.sv
design/sliding_window_sd_rms_top.sv
tb/testbench.sv
